/* sv/fbm_pkg.sv */
`timescale 1ns / 1ps
// Package for the file block map index splitter: widths, level and register
// codes, the configuration and result structs, and the entry split function.
// Depends on nothing; fbm_cfg, fbm_split and the top level import it.
package fbm_pkg;

  // Field widths
  localparam int unsigned POS_W   = 63;
  localparam int unsigned LBN_W   = 51;   // position >> minimum block shift
  localparam int unsigned IDX_W   = 14;   // largest entry index width
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned FRAG_W  = 3;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned KSH_W   = 4;    // entries-per-block shift, 9..14
  localparam int unsigned THR_W   = 29;   // direct + n + n*n fits here
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Number of direct pointers in the inode
  localparam int unsigned DIRECT_POINTERS = 12;

  // Map level codes
  localparam logic [LEVEL_W-1:0] LEVEL_DIRECT = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_SINGLE = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_DOUBLE = 2'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_TRIPLE = 2'd3;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_BLOCK_SHIFT = 2'd0;
  localparam logic [1:0] REG_FRAG_SHIFT  = 2'd1;
  localparam logic [1:0] REG_WIDE_ADDR   = 2'd2;

  // Register reset values
  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd15;
  localparam logic [SHIFT_W-1:0] FRAG_SHIFT_RST  = 5'd12;
  localparam logic               WIDE_ADDR_RST   = 1'b1;

  // Saturation limits
  localparam logic [SHIFT_W-1:0] BSH_MIN = 5'd12;
  localparam logic [SHIFT_W-1:0] BSH_MAX = 5'd16;
  localparam logic [SHIFT_W-1:0] FSH_MIN = 5'd9;

  // Working configuration, derived from the registers
  typedef struct packed {
    logic [SHIFT_W-1:0] bsh;
    logic [SHIFT_W-1:0] fsh;
    logic               wide;
    logic [KSH_W-1:0]   k;
    logic [THR_W-1:0]   thr1;   // first block number past single indirect
    logic [THR_W-1:0]   thr2;   // first block number past double indirect
  } cfg_t;

  typedef struct packed {
    logic [FRAG_W-1:0] frag;
    logic [OFF_W-1:0]  off;
  } entry_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] map_level;
    logic [SLOT_W-1:0]  direct_slot;
    logic [FRAG_W-1:0]  frag_select;
    entry_t             step1;
    entry_t             step2;
    entry_t             step3;
    logic               out_of_range;
  } result_t;

  // Turn an entry index into a fragment of the indirect block and a byte
  // offset within that fragment. The byte offset stays below the block size.
  function automatic entry_t entry_split(input logic [IDX_W-1:0] idx,
                                         input logic wide,
                                         input logic [SHIFT_W-1:0] fsh);
    logic [IDX_W+2:0] byteoff;
    logic [IDX_W+2:0] mask;
    entry_t           e;
    if (wide) begin
      byteoff = {idx, 3'b000};
    end else begin
      byteoff = {1'b0, idx, 2'b00};
    end
    mask   = ({{(IDX_W+2){1'b0}}, 1'b1} << fsh) - {{(IDX_W+2){1'b0}}, 1'b1};
    e.frag = FRAG_W'(byteoff >> fsh);
    e.off  = OFF_W'(byteoff & mask);
    return e;
  endfunction

endpackage

/* sv/fbm_if.sv */
`timescale 1ns / 1ps
// Channel interfaces of the block map index splitter: the mapping request
// and the split result. Depends on nothing.
interface fbm_req_if;
  logic        valid;
  logic        ready;
  logic [62:0] byte_position;

  modport source (output valid, output byte_position, input ready);
  modport sink (input valid, input byte_position, output ready);
endinterface

interface fbm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  map_level;
  logic [3:0]  direct_slot;
  logic [2:0]  frag_select;
  logic [2:0]  step1_frag;
  logic [15:0] step1_offset;
  logic [2:0]  step2_frag;
  logic [15:0] step2_offset;
  logic [2:0]  step3_frag;
  logic [15:0] step3_offset;
  logic        out_of_range;

  modport source (output valid, output map_level, output direct_slot,
                  output frag_select, output step1_frag, output step1_offset,
                  output step2_frag, output step2_offset, output step3_frag,
                  output step3_offset, output out_of_range, input ready);
  modport sink (input valid, input map_level, input direct_slot,
                input frag_select, input step1_frag, input step1_offset,
                input step2_frag, input step2_offset, input step3_frag,
                input step3_offset, input out_of_range, output ready);
endinterface

/* sv/fbm_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers of the block map index splitter behind an APB
// port, plus the registered working configuration derived from them.
// Depends on fbm_pkg.
module fbm_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbm_pkg::ADDR_W-1:0] paddr,
  input  logic [fbm_pkg::DATA_W-1:0] pwdata,
  output logic [fbm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output fbm_pkg::cfg_t              cfg
);
  import fbm_pkg::*;

  logic [SHIFT_W-1:0] block_shift;
  logic [SHIFT_W-1:0] frag_shift;
  logic               wide_addresses;
  logic               wr_en;
  logic [1:0]         reg_idx;
  logic [SHIFT_W-1:0] bsh;
  logic [SHIFT_W-1:0] fsh_lo;
  logic [SHIFT_W-1:0] fsh;
  logic [KSH_W-1:0]   k;
  logic [THR_W-1:0]   n_blk;
  logic [THR_W-1:0]   nn_blk;
  cfg_t               cfg_next;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift    <= BLOCK_SHIFT_RST;
      frag_shift     <= FRAG_SHIFT_RST;
      wide_addresses <= WIDE_ADDR_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BLOCK_SHIFT: block_shift    <= pwdata[SHIFT_W-1:0];
        REG_FRAG_SHIFT:  frag_shift     <= pwdata[SHIFT_W-1:0];
        REG_WIDE_ADDR:   wide_addresses <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      REG_BLOCK_SHIFT: prdata = DATA_W'(block_shift);
      REG_FRAG_SHIFT:  prdata = DATA_W'(frag_shift);
      REG_WIDE_ADDR:   prdata = DATA_W'(wide_addresses);
      default:         prdata = '0;
    endcase
  end

  // Saturate the shifts and work out the level thresholds.
  always_comb begin
    bsh = block_shift;
    if (bsh < BSH_MIN) bsh = BSH_MIN;
    if (bsh > BSH_MAX) bsh = BSH_MAX;
    fsh_lo = bsh - SHIFT_W'(3);
    if (fsh_lo < FSH_MIN) fsh_lo = FSH_MIN;
    fsh = frag_shift;
    if (fsh < fsh_lo) fsh = fsh_lo;
    if (fsh > bsh) fsh = bsh;
    k      = KSH_W'(bsh - SHIFT_W'(2) - SHIFT_W'(wide_addresses));
    n_blk  = {{(THR_W-1){1'b0}}, 1'b1} << k;
    nn_blk = {{(THR_W-1){1'b0}}, 1'b1} << {k, 1'b0};
    cfg_next.bsh  = bsh;
    cfg_next.fsh  = fsh;
    cfg_next.wide = wide_addresses;
    cfg_next.k    = k;
    cfg_next.thr1 = THR_W'(DIRECT_POINTERS) + n_blk;
    cfg_next.thr2 = THR_W'(DIRECT_POINTERS) + n_blk + nn_blk;
  end

  // The working copy is a registered copy of the values derived from the registers;
  // the user keeps the block idle whenever they change; the block does not enforce it.
  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

/* sv/fbm_split.sv */
`timescale 1ns / 1ps
// Combinational split of a byte position into level, direct slot, fragment
// and indirect entry positions. Depends on fbm_pkg.
module fbm_split (
  input  logic [fbm_pkg::POS_W-1:0] pos,
  input  fbm_pkg::cfg_t             cfg,
  output fbm_pkg::result_t          res
);
  import fbm_pkg::*;

  logic [LBN_W-1:0]   lbn;
  logic [LBN_W-1:0]   r1;
  logic [LBN_W-1:0]   r2;
  logic [LBN_W-1:0]   r3;
  logic [OFF_W:0]     blk_mask;
  logic [OFF_W:0]     in_blk;
  logic [IDX_W:0]     k_mask_w;
  logic [IDX_W-1:0]   k_mask;
  logic [SHIFT_W-1:0] k2;
  logic [SHIFT_W:0]   k3;
  logic               oor;

  // Block number and the offsets into each indirect range, in parallel
  assign lbn = LBN_W'(pos >> cfg.bsh);
  assign r1  = lbn - LBN_W'(DIRECT_POINTERS);
  assign r2  = lbn - LBN_W'(cfg.thr1);
  assign r3  = lbn - LBN_W'(cfg.thr2);

  // Fragment of the data block that holds the position
  assign blk_mask = ({{OFF_W{1'b0}}, 1'b1} << cfg.bsh) - {{OFF_W{1'b0}}, 1'b1};
  assign in_blk   = {1'b0, pos[OFF_W-1:0]} & blk_mask;

  assign k_mask_w = ({{IDX_W{1'b0}}, 1'b1} << cfg.k) - {{IDX_W{1'b0}}, 1'b1};
  assign k_mask   = k_mask_w[IDX_W-1:0];
  assign k2       = {cfg.k, 1'b0};
  assign k3       = {1'b0, k2} + {2'b00, cfg.k};
  assign oor      = (r3 >> k3) != '0;

  // Level selection and the entry splits of the walked steps
  always_comb begin
    res              = '0;
    res.frag_select  = FRAG_W'(in_blk >> cfg.fsh);
    priority if (lbn < LBN_W'(DIRECT_POINTERS)) begin
      res.map_level   = LEVEL_DIRECT;
      res.direct_slot = SLOT_W'(lbn);
    end else if (lbn < LBN_W'(cfg.thr1)) begin
      res.map_level = LEVEL_SINGLE;
      res.step1     = entry_split(IDX_W'(r1), cfg.wide, cfg.fsh);
    end else if (lbn < LBN_W'(cfg.thr2)) begin
      res.map_level = LEVEL_DOUBLE;
      res.step1     = entry_split(IDX_W'(r2 >> cfg.k), cfg.wide, cfg.fsh);
      res.step2     = entry_split(IDX_W'(r2) & k_mask, cfg.wide, cfg.fsh);
    end else begin
      res.map_level    = LEVEL_TRIPLE;
      res.out_of_range = oor;
      // An out-of-range top index leaves the first step at zero.
      if (!oor) begin
        res.step1 = entry_split(IDX_W'(r3 >> k2) & k_mask, cfg.wide, cfg.fsh);
      end
      res.step2 = entry_split(IDX_W'(r3 >> cfg.k) & k_mask, cfg.wide, cfg.fsh);
      res.step3 = entry_split(IDX_W'(r3) & k_mask, cfg.wide, cfg.fsh);
    end
  end

endmodule

/* sv/file_block_map_index_split_unit.sv */
`timescale 1ns / 1ps
// Top level of the file block map index splitter: input register, split
// logic, result register and APB configuration.
// Depends on fbm_pkg, fbm_if, fbm_cfg and fbm_split.
//
//   Channel   Dir   Handshake        Carries
//   request   in    valid / ready    byte_position
//   result    out   valid / ready    map_level .. out_of_range
//   APB       in    psel / penable   block_shift, frag_shift, wide_addresses
//
// A request is registered in the input register, split by the combinational
// logic and held in the result register, which offers it. One request per
// cycle is sustained while the result side takes each result. The input
// and result registers form a two-stage pipeline, so a request is still
// taken while a result waits to be taken, if the input stage is empty.
// Reset is synchronous, clears the stage valid flags and returns the
// configuration registers to their reset values.
// A stall on the result side backs up one stage at a time.
module file_block_map_index_split_unit (
  input  logic                       clk,
  input  logic                       rst,
  fbm_req_if.sink                    request,
  fbm_res_if.source                  result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbm_pkg::ADDR_W-1:0] paddr,
  input  logic [fbm_pkg::DATA_W-1:0] pwdata,
  output logic [fbm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import fbm_pkg::*;

  cfg_t             cfg;
  logic             s1_valid;
  logic [POS_W-1:0] s1_pos;
  logic             s1_advance;
  logic             out_valid;
  result_t          res_next;
  result_t          res_q;

  fbm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbm_split u_split (
    .pos (s1_pos),
    .cfg (cfg),
    .res (res_next)
  );

  // Pipeline flow control
  assign s1_advance    = s1_valid && (!out_valid || result.ready);
  assign request.ready = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (request.ready) begin
      s1_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_pos <= request.byte_position;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      res_q <= res_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.map_level    = res_q.map_level;
  assign result.direct_slot  = res_q.direct_slot;
  assign result.frag_select  = res_q.frag_select;
  assign result.step1_frag   = res_q.step1.frag;
  assign result.step1_offset = res_q.step1.off;
  assign result.step2_frag   = res_q.step2.frag;
  assign result.step2_offset = res_q.step2.off;
  assign result.step3_frag   = res_q.step3.frag;
  assign result.step3_offset = res_q.step3.off;
  assign result.out_of_range = res_q.out_of_range;

  // A request is refused only when both stages are occupied.
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !request.ready |-> (s1_valid && out_valid))
    else $error("request refused with a free stage");

  // A held input stage keeps its position while the result side stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_pos)))
    else $error("input stage lost its request during a stall");

  // Out of range is only flagged on a triple-indirect result.
  a_oor_level: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.out_of_range) |-> (result.map_level == LEVEL_TRIPLE))
    else $error("out of range flagged below triple indirect");

  // A direct result walks no indirect step.
  a_direct_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.map_level == LEVEL_DIRECT)) |->
      (result.step1_offset == '0 && result.step2_offset == '0 &&
       result.step3_offset == '0 && !result.out_of_range))
    else $error("direct result carries indirect step data");

endmodule
